### sv/rms_pkg.sv
// Package: shared types and constants of the true-RMS voltage meter.
package rms_pkg;

   localparam int CNT_W = 13;
   localparam int SUM_W = 25;
   localparam int SQ_W  = 37;
   localparam int DVD_W = 48;
   localparam int DVS_W = 18;

   localparam logic [27:0] OFFSET_RESET = 28'd108134400;
   localparam logic [11:0] MV_MAX       = 12'd4095;
   localparam logic [47:0] VOLT_MAX     = 48'd8388607;
   localparam logic [47:0] SCALE_RND    = 48'd128000;

   // divide by 256000 = 2^11 * 125; the 1/125 step is a reciprocal multiply
   localparam int          SCALE_SHR    = 11;
   localparam int          RECIP_SHR    = 37;
   localparam logic [30:0] SCALE_RECIP  = 31'd1099511628;

   localparam logic       OP_MEAS = 1'b0;
   localparam logic       OP_CAL  = 1'b1;

   localparam logic [1:0] CSR_CAL_GAIN    = 2'd0;
   localparam logic [1:0] CSR_NOISE_FLOOR = 2'd1;
   localparam logic [1:0] CSR_MIN_CUTOFF  = 2'd2;
   localparam logic [1:0] CSR_OFFSET_SHIFT = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [11:0] sample_mv;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [22:0] filtered_volts;
      logic [22:0] raw_volts;
      logic [23:0] mean_square_mv2;
      logic [11:0] new_offset_mv;
   } rsp_type;

   typedef struct packed {
      logic             opcode;
      logic [SQ_W-1:0]  sq;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
   } win_type;

   typedef struct packed {
      logic [19:0] cal_gain;
      logic [11:0] noise_floor_mv;
      logic [22:0] min_cutoff;
      logic [4:0]  offset_shift;
   } cfg_type;

   typedef struct packed {
      logic        off_busy;
      logic [11:0] off_mv;
   } stat_type;

endpackage

### sv/true_rms_voltage_meter.sv
// Top level of the true-RMS voltage meter: registers, front end, queue, back end.
// Usage:
//   req_* carries one sample word per accepted edge (req_valid high, req_stall low).
//   A word with last set closes a window (opcode 0) or a calibration run (opcode 1).
//   rsp_* returns one result word per closed window; it is taken when rsp_valid is
//   high and rsp_stall is low. csr_* writes the four setup registers; csr_ready is
//   always high and writes belong to idle periods.
// Timing:
//   Samples inside a window are taken one per cycle. After the closing word the
//   front end holds req_stall until the back end has updated the offset, which
//   takes one restoring division. A measurement result then needs two more
//   divisions on the shared bit-serial divider and a 20-step square root.
//   The next window accumulates meanwhile.
// Reset: offset returns to 1650 mV, accumulators, averaging ring and registers to
//   their defaults; the ring memory itself is not cleared, only its fill count.
// Stall: a result held on rsp_* stays put; the back end waits with its next result
//   and the next closing word then sits in the queue, stalling the sample input.
module true_rms_voltage_meter #(
   parameter int MAX_SAMPLES = 1024,
   parameter int AVG_DEPTH   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rms_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [22:0]      csr_wdata
);
   import rms_pkg::*;

   cfg_type  cfg_ff;
   stat_type stat;
   win_type  push_data;
   win_type  pop_data;
   logic     push;
   logic     pop;
   logic     q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cal_gain: 20'd256, noise_floor_mv: 12'd45,
                     min_cutoff: 23'd768, offset_shift: 5'd10};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAL_GAIN:     cfg_ff.cal_gain       <= csr_wdata[19:0];
            CSR_NOISE_FLOOR:  cfg_ff.noise_floor_mv <= csr_wdata[11:0];
            CSR_MIN_CUTOFF:   cfg_ff.min_cutoff     <= csr_wdata;
            CSR_OFFSET_SHIFT: cfg_ff.offset_shift   <= csr_wdata[4:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   rms_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .stat, .q_empty, .push, .push_data
   );

   rms_fifo u_fifo (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .empty(q_empty)
   );

   rms_back #(.AVG_DEPTH(AVG_DEPTH)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_empty, .q_data(pop_data), .pop, .stat,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

### sv/rms_front.sv
// Front end: centers, squares and accumulates samples, emits one word per window.
module rms_front #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rms_pkg::req_type  req_data,
   input  rms_pkg::stat_type stat,
   input  logic              q_empty,
   output logic              push,
   output rms_pkg::win_type  push_data
);
   import rms_pkg::*;

   logic [SQ_W-1:0]  sq_ff,  sq_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             take;
   logic [11:0]      d;
   logic [23:0]      dd;

   always_comb begin
      req_stall = !q_empty || stat.off_busy;
      accept    = req_valid && !req_stall;
      take      = cnt_ff < CNT_W'(MAX_SAMPLES);
      d         = (req_data.sample_mv >= stat.off_mv) ? req_data.sample_mv - stat.off_mv
                                                      : stat.off_mv - req_data.sample_mv;
      dd        = 24'(d) * 24'(d);
      sq_in     = take ? sq_ff + SQ_W'(dd) : sq_ff;
      sum_in    = take ? sum_ff + SUM_W'(req_data.sample_mv) : sum_ff;
      cnt_in    = take ? cnt_ff + CNT_W'(1) : cnt_ff;
      push      = accept && req_data.last;
      push_data = '{opcode: req_data.opcode, sq: sq_in, sum: sum_in, cnt: cnt_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff  <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (accept) begin
         if (req_data.last) begin
            sq_ff  <= '0;
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            sq_ff  <= sq_in;
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
         end
      end
   end

endmodule

### sv/rms_fifo.sv
// Two-entry queue of window words between front and back end.
module rms_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rms_pkg::win_type push_data,
   input  logic             pop,
   output rms_pkg::win_type pop_data,
   output logic             empty
);
   import rms_pkg::*;

   win_type    mem_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;

   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && cnt_ff != 2'd2) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && cnt_ff != 2'd2) begin
            wr_ff <= !wr_ff;
         end
         if (pop && !empty) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'((push && cnt_ff != 2'd2) ? 1 : 0)
                          - 2'((pop && !empty) ? 1 : 0);
      end
   end

endmodule

### sv/rms_back.sv
// Back end: offset update, mean square, root, scaling and moving average per window (calibration: offset only).
module rms_back #(
   parameter int AVG_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  rms_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  rms_pkg::win_type  q_data,
   output logic              pop,
   output rms_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rms_pkg::rsp_type  rsp_data
);
   import rms_pkg::*;

   localparam int FILL_W = $clog2(AVG_DEPTH + 1);
   localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int RSUM_W = 23 + FILL_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_MEAN, ST_MS, ST_SQRT, ST_ROOT, ST_SCALE,
      ST_RING_RD, ST_RING_UPD, ST_FILT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {TAG_MEAN, TAG_MS, TAG_FILT} tag_type;

   state_type         state_ff;
   tag_type           tag_ff;
   win_type           win_ff;
   logic [27:0]       dc_ff;
   logic              busy_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [5:0]        step_ff;
   logic [39:0]       sx_ff;
   logic [39:0]       sres_ff;
   logic [39:0]       sbit_ff;
   logic [23:0]       ms_ff;
   logic [22:0]       raw_ff;
   logic [22:0]       filt_ff;
   logic [22:0]       rd_ff;
   logic [RSUM_W-1:0] rsum_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;
   logic [22:0]       ring_mem [AVG_DEPTH];

   logic [12:0]       off_round;
   logic [11:0]       off_mv;
   logic [DVS_W:0]    rem_sh;
   logic              rem_ge;
   logic [27:0]       mean;
   logic [27:0]       delta;
   logic [40:0]       st;
   logic [19:0]       root;
   logic [29:0]       scl_y;
   logic [60:0]       scl_p;
   logic [23:0]       scl_q;
   logic [47:0]       vol;
   logic              full;
   logic [RSUM_W-1:0] rsum_new;
   logic [FILL_W-1:0] fill_new;
   logic              mem_we;

   always_comb begin
      off_round = 13'((29'(dc_ff) + 29'h8000) >> 16);
      off_mv    = (off_round > 13'(MV_MAX)) ? MV_MAX : off_round[11:0];
      stat      = '{off_busy: busy_ff, off_mv: off_mv};
      rem_sh    = {rem_ff, quo_ff[DVD_W-1]};
      rem_ge    = rem_sh >= {1'b0, dvs_ff};
      mean      = quo_ff[27:0];
      delta     = (mean >= dc_ff) ? mean - dc_ff : dc_ff - mean;
      st        = 41'(sres_ff) + 41'(sbit_ff);
      root      = sres_ff[19:0];
      scl_y     = quo_ff[SCALE_SHR+29:SCALE_SHR];
      scl_p     = 61'(scl_y) * 61'(SCALE_RECIP);
      scl_q     = scl_p[RECIP_SHR+23:RECIP_SHR];
      vol       = (48'(scl_q) > VOLT_MAX) ? VOLT_MAX : 48'(scl_q);
      full      = fill_ff == FILL_W'(AVG_DEPTH);
      rsum_new  = rsum_ff - (full ? RSUM_W'(rd_ff) : '0) + RSUM_W'(raw_ff);
      fill_new  = full ? fill_ff : fill_ff + FILL_W'(1);
      pop       = state_ff == ST_IDLE && !q_empty;
      mem_we    = state_ff == ST_RING_UPD;
      rsp_valid = out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[pos_ff] <= raw_ff;
      end
      rd_ff <= ring_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_ff       <= TAG_MEAN;
         dc_ff        <= OFFSET_RESET;
         busy_ff      <= 1'b0;
         rsum_ff      <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  win_ff  <= q_data;
                  ms_ff   <= '0;
                  raw_ff  <= '0;
                  filt_ff <= '0;
                  if (q_data.cnt != '0) begin
                     busy_ff  <= 1'b1;
                     quo_ff   <= DVD_W'({q_data.sum, 16'b0});
                     rem_ff   <= '0;
                     dvs_ff   <= DVS_W'(q_data.cnt);
                     step_ff  <= '0;
                     tag_ff   <= TAG_MEAN;
                     state_ff <= ST_DIV;
                  end else if (q_data.opcode == OP_CAL) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_RING_RD;
                  end
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
               quo_ff  <= {quo_ff[DVD_W-2:0], rem_ge};
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'(DVD_W - 1)) begin
                  case (tag_ff)
                     TAG_MEAN:  state_ff <= ST_MEAN;
                     TAG_MS:    state_ff <= ST_MS;
                     default:   state_ff <= ST_FILT;
                  endcase
               end
            end
            ST_MEAN: begin
               busy_ff <= 1'b0;
               if (win_ff.opcode == OP_CAL) begin
                  dc_ff    <= mean;
                  state_ff <= ST_OUT;
               end else begin
                  if (mean >= dc_ff) begin
                     dc_ff <= dc_ff + (delta >> cfg.offset_shift);
                  end else begin
                     dc_ff <= dc_ff - (delta >> cfg.offset_shift);
                  end
                  quo_ff   <= DVD_W'(win_ff.sq);
                  rem_ff   <= '0;
                  dvs_ff   <= DVS_W'(win_ff.cnt);
                  step_ff  <= '0;
                  tag_ff   <= TAG_MS;
                  state_ff <= ST_DIV;
               end
            end
            ST_MS: begin
               ms_ff    <= quo_ff[23:0];
               sx_ff    <= {quo_ff[23:0], 16'b0};
               sres_ff  <= '0;
               sbit_ff  <= 40'h1 << 38;
               step_ff  <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (41'(sx_ff) >= st) begin
                  sx_ff   <= 40'(41'(sx_ff) - st);
                  sres_ff <= (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_ff <= sres_ff >> 1;
               end
               sbit_ff <= sbit_ff >> 2;
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd19) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root >= {cfg.noise_floor_mv, 8'b0}) begin
                  quo_ff   <= 48'(40'(root) * 40'(cfg.cal_gain)) + SCALE_RND;
                  state_ff <= ST_SCALE;
               end else begin
                  state_ff <= ST_RING_RD;
               end
            end
            ST_SCALE: begin
               raw_ff   <= (vol >= 48'(cfg.min_cutoff)) ? vol[22:0] : '0;
               state_ff <= ST_RING_RD;
            end
            ST_RING_RD: begin
               state_ff <= ST_RING_UPD;
            end
            ST_RING_UPD: begin
               rsum_ff  <= rsum_new;
               fill_ff  <= fill_new;
               pos_ff   <= (pos_ff == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_ff + POS_W'(1);
               quo_ff   <= DVD_W'(rsum_new) + DVD_W'(fill_new >> 1);
               rem_ff   <= '0;
               dvs_ff   <= DVS_W'(fill_new);
               step_ff  <= '0;
               tag_ff   <= TAG_FILT;
               state_ff <= ST_DIV;
            end
            ST_FILT: begin
               filt_ff  <= quo_ff[22:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!out_valid_ff || !rsp_stall) begin
                  out_ff <= '{kind: win_ff.opcode, filtered_volts: filt_ff,
                              raw_volts: raw_ff, mean_square_mv2: ms_ff,
                              new_offset_mv: off_mv};
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
